// ----- hw/rtl/key_value_pair_sorter_top_defines.svh -----
// Assertion macros used by the sorter top module.
`ifndef KEY_VALUE_PAIR_SORTER_TOP_DEFINES_SVH
`define KEY_VALUE_PAIR_SORTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define KVPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
`define KVPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define KVPS_ASSERT(lbl, clk, rst_n, prop)
`define KVPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/kvps_pkg.sv -----
package kvps_pkg;

  localparam int unsigned KeyWidth     = 32;
  localparam int unsigned PayloadWidth = 64;

  // Contents of one sorting cell.
  typedef struct packed {
    logic                           valid;
    logic signed [KeyWidth-1:0]     key;
    logic        [PayloadWidth-1:0] payload;
  } entry_t;

  // Chain-wide control, the same for every cell.
  typedef struct packed {
    logic load;   // insert the broadcast pair
    logic drain;  // shift every cell one place toward the output
  } chain_ctrl_t;

endpackage

// ----- hw/rtl/kvps_cell.sv -----
module kvps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  kvps_pkg::chain_ctrl_t ctrl,
  input  kvps_pkg::entry_t    new_entry,
  input  kvps_pkg::entry_t    left_entry,
  input  logic                left_gt,
  input  kvps_pkg::entry_t    right_entry,
  output kvps_pkg::entry_t    entry,
  output logic                gt
);

  kvps_pkg::entry_t entry_r;
  kvps_pkg::entry_t entry_nxt;

  // An empty cell counts as holding a key above every other, so a new pair
  // lands in the first cell whose key is strictly greater (ties stay behind).
  assign gt = !entry_r.valid || (entry_r.key > new_entry.key);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.drain) begin
      entry_nxt = right_entry;
    end else if (ctrl.load && gt) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else begin
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r.key     <= entry_nxt.key;
    entry_r.payload <= entry_nxt.payload;
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
  end

  assign entry = entry_r;

endmodule

// ----- hw/rtl/key_value_pair_sorter_top.sv -----
// Channel  | Ports                                                  | Handshake
// input    | in_key, in_payload, in_last_item                       | start & !busy
// result   | out_sorted_key, out_sorted_payload, out_end_of_list,   | out_valid strobe
//          | out_overflow                                           |
// One pair is taken per cycle while loading; each is sorted into the cell chain at once.
// After the last pair, the chain drains one pair per cycle toward cell 0, so a list of
// N stored pairs yields N results on consecutive cycles; after the last pair is taken,
// busy_r is set and then cell 0 is registered into the output registers.
// busy is high from the cycle after the last pair and drops as the final
// result is shown, so the next list can start in that cycle.
// Synchronous active-low reset empties the chain and clears the overflow flag.
// The receiver cannot stall; results are never held.
`include "key_value_pair_sorter_top_defines.svh"

module key_value_pair_sorter_top #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_key,
  input  logic        [63:0]  in_payload,
  input  logic                in_last_item,
  output logic                out_valid,
  output logic signed [31:0]  out_sorted_key,
  output logic        [63:0]  out_sorted_payload,
  output logic                out_end_of_list,
  output logic                out_overflow
);

  kvps_pkg::entry_t      cell_q  [MAX_ENTRIES];
  logic                  cell_gt [MAX_ENTRIES];
  kvps_pkg::entry_t      new_entry;
  kvps_pkg::entry_t      empty_entry;
  kvps_pkg::chain_ctrl_t ctrl;

  logic accept;
  logic full;
  logic final_drain;

  logic busy_r,     busy_nxt;
  logic overflow_r, overflow_nxt;
  logic out_valid_r;
  logic signed [31:0] out_key_r;
  logic [63:0]        out_payload_r;
  logic               out_eol_r;
  logic               out_ovf_r;

  assign accept      = start && !busy_r;
  assign full        = cell_q[MAX_ENTRIES-1].valid;
  assign final_drain = busy_r && !cell_q[1].valid;

  assign new_entry.valid   = 1'b1;
  assign new_entry.key     = in_key;
  assign new_entry.payload = in_payload;

  assign empty_entry.valid   = 1'b0;
  assign empty_entry.key     = '0;
  assign empty_entry.payload = '0;

  assign ctrl.load  = accept && !full;
  assign ctrl.drain = busy_r;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    kvps_pkg::entry_t left_e;
    kvps_pkg::entry_t right_e;
    logic             left_g;

    if (i == 0) begin : g_head
      assign left_e = empty_entry;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_e = cell_q[i-1];
      assign left_g = cell_gt[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_e = empty_entry;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    kvps_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .gt          (cell_gt[i])
    );
  end

  always_comb begin
    busy_nxt     = busy_r;
    overflow_nxt = overflow_r;
    if (accept) begin
      if (full) begin
        overflow_nxt = 1'b1;
      end
      if (in_last_item) begin
        busy_nxt = 1'b1;
      end
    end else if (final_drain) begin
      busy_nxt     = 1'b0;
      overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_key_r     <= cell_q[0].key;
    out_payload_r <= cell_q[0].payload;
    out_eol_r     <= final_drain;
    out_ovf_r     <= overflow_r;
    if (!rst_n) begin
      busy_r      <= 1'b0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= busy_r;
    end
  end

  assign busy               = busy_r;
  assign out_valid          = out_valid_r;
  assign out_sorted_key     = out_key_r;
  assign out_sorted_payload = out_payload_r;
  assign out_end_of_list    = out_valid_r && out_eol_r;
  assign out_overflow       = out_ovf_r;

  `KVPS_ASSERT(a_drain_has_data, clk, rst_n, busy_r |-> cell_q[0].valid)
  `KVPS_ASSERT(a_drain_contiguous, clk, rst_n, (out_valid_r && !out_eol_r) |=> out_valid_r)
  `KVPS_ASSERT(a_ascending, clk, rst_n, (out_valid_r && !out_eol_r) |=> (out_key_r >= $past(out_key_r)))
  `KVPS_ASSERT(a_list_ends_idle, clk, rst_n, (out_valid_r && out_eol_r) |-> (!busy_r && !overflow_r))

endmodule

// ----- tb/tb_key_value_pair_sorter_top.sv -----
module tb_key_value_pair_sorter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KeyWidth     = kvps_pkg::KeyWidth;
  localparam int PayloadWidth = kvps_pkg::PayloadWidth;

  localparam int MaxEntries   = 64;
  localparam int StallLimit   = 1000;
  localparam int RandomTarget = 240;

  typedef struct {
    logic signed [KeyWidth-1:0]     key;
    logic        [PayloadWidth-1:0] payload;
    logic                           last;
  } pair_t;

  typedef struct {
    logic signed [KeyWidth-1:0]     key;
    logic        [PayloadWidth-1:0] payload;
    logic                           end_of_list;
    logic                           overflow;
  } sorted_pair_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic signed [KeyWidth-1:0]     in_key = '0;
  logic        [PayloadWidth-1:0] in_payload = '0;
  logic                           in_last_item = 1'b0;
  logic                           out_valid;
  logic signed [KeyWidth-1:0]     out_sorted_key;
  logic        [PayloadWidth-1:0] out_sorted_payload;
  logic                           out_end_of_list;
  logic                           out_overflow;

  key_value_pair_sorter_top #(
    .MAX_ENTRIES(MaxEntries)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_sorted_key    (out_sorted_key),
    .out_sorted_payload(out_sorted_payload),
    .out_end_of_list   (out_end_of_list),
    .out_overflow      (out_overflow)
  );

  always #6 clk = ~clk;

  pair_t        pending_pairs[$];
  sorted_pair_t sorted_pairs_due[$];

  // Model of the cell chain: pairs held in ascending key order.
  logic signed [KeyWidth-1:0]     held_keys[MaxEntries];
  logic        [PayloadWidth-1:0] held_payloads[MaxEntries];
  int                             held_count = 0;
  logic                           pairs_dropped = 1'b0;

  int fail_count = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int random_items = 0;

  function automatic void sort_in_pair(pair_t p);
    int pos;
    sorted_pair_t r;
    if (held_count >= MaxEntries) begin
      pairs_dropped = 1'b1;
    end else begin
      pos = held_count;
      // Equal keys stay in front of the new pair, so ties keep arrival order.
      while (pos > 0 && held_keys[pos-1] > p.key) begin
        held_keys[pos]     = held_keys[pos-1];
        held_payloads[pos] = held_payloads[pos-1];
        pos--;
      end
      held_keys[pos]     = p.key;
      held_payloads[pos] = p.payload;
      held_count++;
    end
    if (p.last) begin
      for (int i = 0; i < held_count; i++) begin
        r.key         = held_keys[i];
        r.payload     = held_payloads[i];
        r.end_of_list = (i == held_count - 1);
        r.overflow    = pairs_dropped;
        sorted_pairs_due.push_back(r);
      end
      held_count    = 0;
      pairs_dropped = 1'b0;
    end
  endfunction

  task automatic queue_pair(logic signed [KeyWidth-1:0] key,
                            logic [PayloadWidth-1:0] payload, logic last);
    pair_t p;
    p.key     = key;
    p.payload = payload;
    p.last    = last;
    pending_pairs.push_back(p);
  endtask

  task automatic queue_random_list(int n);
    int key_style;
    logic signed [KeyWidth-1:0] key;
    logic [PayloadWidth-1:0] payload;
    key_style = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case (key_style)
        1: key = int'($urandom_range(0, 6)) - 3;
        2: begin
          case ($urandom_range(0, 4))
            0: key = 32'sh7FFF_FFFF;
            1: key = 32'sh8000_0000;
            2: key = '0;
            3: key = -1;
            default: key = $urandom;
          endcase
        end
        default: key = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0: payload = '0;
        1: payload = '1;
        default: payload = {$urandom, $urandom};
      endcase
      queue_pair(key, payload, i == n - 1);
      random_items++;
    end
  endtask

  // Inputs change on the falling edge; the sender alternates bursts and gaps.
  always @(negedge clk) begin
    if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start    <= 1'b0;
    end else if (rst_n && pending_pairs.size() != 0) begin
      start        <= 1'b1;
      in_key       <= pending_pairs[0].key;
      in_payload   <= pending_pairs[0].payload;
      in_last_item <= pending_pairs[0].last;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    logic progress;
    sorted_pair_t want;
    progress = 1'b0;
    if (rst_n && out_valid !== 1'b0) begin
      progress = 1'b1;
      if (sorted_pairs_due.size() == 0) begin
        $error("unexpected result transaction: key %0d payload %h",
               out_sorted_key, out_sorted_payload);
        fail_count++;
      end else begin
        want = sorted_pairs_due.pop_front();
        if (out_sorted_key !== want.key) begin
          $error("sorted_key: expected %0d, actual %0d", want.key, out_sorted_key);
          fail_count++;
        end
        if (out_sorted_payload !== want.payload) begin
          $error("sorted_payload: expected %h, actual %h",
                 want.payload, out_sorted_payload);
          fail_count++;
        end
        if (out_end_of_list !== want.end_of_list) begin
          $error("end_of_list: expected %0b, actual %0b",
                 want.end_of_list, out_end_of_list);
          fail_count++;
        end
        if (out_overflow !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, out_overflow);
          fail_count++;
        end
      end
    end
    if (rst_n && start && busy === 1'b0) begin
      progress = 1'b1;
      sort_in_pair(pending_pairs.pop_front());
    end
    if (progress) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n;
    // Single-pair lists at both key extremes, back to back.
    queue_pair(32'sh7FFF_FFFF, '1, 1'b1);
    queue_pair(32'sh8000_0000, '0, 1'b1);
    // Strictly descending extremes.
    queue_pair(32'sh7FFF_FFFF, 64'h0123_4567_89AB_CDEF, 1'b0);
    queue_pair(1, 64'hFFFF_FFFF_0000_0000, 1'b0);
    queue_pair(0, 64'h0000_0000_FFFF_FFFF, 1'b0);
    queue_pair(-1, 64'h8000_0000_0000_0001, 1'b0);
    queue_pair(32'sh8000_0000, 64'h7FF0_0000_0000_0000, 1'b1);
    // Repeated keys must come out in arrival order.
    queue_pair(5, 64'd1, 1'b0);
    queue_pair(-5, 64'd2, 1'b0);
    queue_pair(5, 64'd3, 1'b0);
    queue_pair(5, 64'd4, 1'b0);
    queue_pair(-5, 64'd5, 1'b0);
    queue_pair(5, 64'd6, 1'b1);
    // Already ascending.
    queue_pair(-100, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_pair(-2, 64'h5555_5555_5555_5555, 1'b0);
    queue_pair(3, 64'hDEAD_BEEF_0000_0001, 1'b0);
    queue_pair(1000, 64'h3FF0_0000_0000_0000, 1'b1);

    // Mostly short lists; one exactly at capacity and one past it.
    for (int l = 0; random_items < RandomTarget; l++) begin
      if (l == 4) begin
        n = MaxEntries;
      end else if (l == 9) begin
        n = MaxEntries + 2;
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
      end else begin
        n = $urandom_range(2, 12);
      end
      queue_random_list(n);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || sorted_pairs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (MaxEntries + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
